### sv/tccf_pkg.sv
package tccf_pkg;

	localparam int unsigned SEQ_W = 32;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned CODE_W = 3;

	typedef enum logic [1:0] {
		ACT_CONNECT = 2'd0,
		ACT_CLOSE   = 2'd1,
		ACT_SEND    = 2'd2,
		ACT_RX      = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		TX_NONE   = 3'd0,
		TX_SYN    = 3'd1,
		TX_FIN    = 3'd2,
		TX_DATA   = 3'd3,
		TX_ACK    = 3'd4,
		TX_FINACK = 3'd5
	} tx_kind_t;

	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_CONNECTED = 2'd1,
		EV_MESSAGE   = 2'd2,
		EV_CLOSED    = 2'd3
	} event_t;

	typedef enum logic [6:0] {
		ST_CLOSED      = 7'b0000001,
		ST_SYN_SENT    = 7'b0000010,
		ST_ESTABLISHED = 7'b0000100,
		ST_FIN_WAIT1   = 7'b0001000,
		ST_FIN_WAIT2   = 7'b0010000,
		ST_CLOSING     = 7'b0100000,
		ST_TIME_WAIT   = 7'b1000000
	} state_t;

	localparam logic [CODE_W-1:0] CODE_CLOSED      = 3'd0;
	localparam logic [CODE_W-1:0] CODE_SYN_SENT    = 3'd1;
	localparam logic [CODE_W-1:0] CODE_ESTABLISHED = 3'd2;
	localparam logic [CODE_W-1:0] CODE_FIN_WAIT1   = 3'd3;
	localparam logic [CODE_W-1:0] CODE_FIN_WAIT2   = 3'd4;
	localparam logic [CODE_W-1:0] CODE_CLOSING     = 3'd5;
	localparam logic [CODE_W-1:0] CODE_TIME_WAIT   = 3'd6;

	typedef struct packed {
		action_t           action;
		logic [LEN_W-1:0]  send_length;
		logic [SEQ_W-1:0]  rx_sequence;
		logic [LEN_W-1:0]  rx_length;
		logic              rx_syn;
		logic              rx_ack;
		logic              rx_fin;
	} req_t;

	typedef struct packed {
		tx_kind_t          tx_kind;
		logic [SEQ_W-1:0]  tx_sequence;
		logic [SEQ_W-1:0]  tx_acknowledge;
		logic [LEN_W-1:0]  tx_length;
		event_t            event_res;
		logic [LEN_W-1:0]  message_length;
		logic [CODE_W-1:0] conn_state;
	} rsp_t;

	function automatic logic [CODE_W-1:0] state_code(input state_t st);
		logic [CODE_W-1:0] code;
		code = CODE_CLOSED;
		case (st)
			ST_SYN_SENT:    code = CODE_SYN_SENT;
			ST_ESTABLISHED: code = CODE_ESTABLISHED;
			ST_FIN_WAIT1:   code = CODE_FIN_WAIT1;
			ST_FIN_WAIT2:   code = CODE_FIN_WAIT2;
			ST_CLOSING:     code = CODE_CLOSING;
			ST_TIME_WAIT:   code = CODE_TIME_WAIT;
			default:        code = CODE_CLOSED;
		endcase
		return code;
	endfunction

endpackage

### sv/tcp_client_connection_fsm.sv
// Client-side TCP connection state machine. Each request transaction (connect, close,
// send data, or a received segment's flags, seq and length) yields exactly one response
// transaction: the segment to transmit with its seq/ack, an event and the state after
// the step. Throughput is one transaction per cycle while rsp_stall is low. The response is
// registered: an accepted request passes through the input register, then the result register;
// a stalled response holds the input register, and req_stall follows rsp_stall in the
// same cycle. The connection state, send sequence and acknowledge number update in the
// cycle an item moves into the result register, so the next item sees them at once.
// Sequence arithmetic wraps modulo 2^32. A write on the cfg port sets the initial
// sequence and reloads the send sequence; write it only while no transaction is in flight.
module tcp_client_connection_fsm
	import tccf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SEQ_W-1:0] cfg_data
);

	logic             valid_s1;
	req_t             req_s1;
	logic             move_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	state_t           state_q;
	logic [SEQ_W-1:0] snd_seq_q;
	logic [SEQ_W-1:0] ack_num_q;

	state_t           state_nx;
	logic [SEQ_W-1:0] snd_seq_nx;
	logic [SEQ_W-1:0] ack_num_nx;
	logic [SEQ_W-1:0] rx_ack_val;
	rsp_t             rsp_nx;

	assign move_s1   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !move_s1;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// acknowledge number a received segment implies
	assign rx_ack_val = req_s1.rx_sequence + ((req_s1.rx_length != '0) ?
		SEQ_W'(req_s1.rx_length) : SEQ_W'(1));

	always_comb begin
		state_nx   = state_q;
		snd_seq_nx = snd_seq_q;
		ack_num_nx = ack_num_q;
		rsp_nx     = '0;
		case (req_s1.action)
			ACT_CONNECT: begin
				rsp_nx.tx_kind     = TX_SYN;
				rsp_nx.tx_sequence = snd_seq_q;
				snd_seq_nx         = snd_seq_q + SEQ_W'(1);
				state_nx           = ST_SYN_SENT;
			end
			ACT_CLOSE: begin
				rsp_nx.tx_kind        = TX_FIN;
				rsp_nx.tx_sequence    = snd_seq_q;
				rsp_nx.tx_acknowledge = ack_num_q;
				snd_seq_nx            = snd_seq_q + SEQ_W'(1);
				state_nx              = ST_FIN_WAIT1;
			end
			ACT_SEND: begin
				rsp_nx.tx_kind        = TX_DATA;
				rsp_nx.tx_sequence    = snd_seq_q;
				rsp_nx.tx_acknowledge = ack_num_q;
				rsp_nx.tx_length      = req_s1.send_length;
				snd_seq_nx            = snd_seq_q + SEQ_W'(req_s1.send_length);
			end
			default: begin
				ack_num_nx = rx_ack_val;
				case (state_q)
					ST_SYN_SENT: begin
						if (req_s1.rx_syn && req_s1.rx_ack) begin
							rsp_nx.tx_kind   = TX_ACK;
							rsp_nx.event_res = EV_CONNECTED;
							state_nx         = ST_ESTABLISHED;
						end
					end
					ST_ESTABLISHED: begin
						if (req_s1.rx_length != '0) begin
							rsp_nx.tx_kind        = TX_ACK;
							rsp_nx.event_res      = EV_MESSAGE;
							rsp_nx.message_length = req_s1.rx_length;
						end else if (!req_s1.rx_ack && req_s1.rx_fin) begin
							rsp_nx.tx_kind = TX_FINACK;
							state_nx       = ST_CLOSING;
						end
					end
					ST_FIN_WAIT1: begin
						if (req_s1.rx_ack) begin
							state_nx = ST_FIN_WAIT2;
						end else if (req_s1.rx_fin) begin
							rsp_nx.tx_kind = TX_ACK;
							state_nx       = ST_CLOSING;
						end
					end
					ST_FIN_WAIT2: begin
						if (req_s1.rx_fin) begin
							rsp_nx.tx_kind   = TX_ACK;
							rsp_nx.event_res = EV_CLOSED;
							state_nx         = ST_CLOSED;
						end
					end
					ST_CLOSING: begin
						if (req_s1.rx_ack) begin
							rsp_nx.event_res = EV_CLOSED;
							state_nx         = ST_CLOSED;
						end
					end
					default: begin
					end
				endcase
				if (rsp_nx.tx_kind != TX_NONE) begin
					rsp_nx.tx_sequence    = snd_seq_q;
					rsp_nx.tx_acknowledge = rx_ack_val;
				end
			end
		endcase
		rsp_nx.conn_state = state_code(state_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			state_q     <= ST_CLOSED;
			snd_seq_q   <= '0;
			ack_num_q   <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				// reload the send sequence with the new initial value
				snd_seq_q <= cfg_data;
			end else if (move_s1) begin
				snd_seq_q <= snd_seq_nx;
			end
			if (move_s1) begin
				state_q   <= state_nx;
				ack_num_q <= ack_num_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (move_s1) begin
			rsp_q <= rsp_nx;
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !req_stall)
		else $error("request stalled with empty input register");

	a_connect_gives_syn: assert property (@(posedge clk) disable iff (!arst_n)
		(move_s1 && req_s1.action == ACT_CONNECT) |=>
		(rsp_valid && rsp.tx_kind == TX_SYN && rsp.conn_state == CODE_SYN_SENT))
		else $error("connect did not produce SYN in syn_sent");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.tx_kind == TX_NONE) |->
		(rsp.tx_sequence == '0 && rsp.tx_acknowledge == '0 && rsp.tx_length == '0))
		else $error("no-segment response carries nonzero seq, ack or length");

	a_closed_event_state: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.event_res == EV_CLOSED) |-> rsp.conn_state == CODE_CLOSED)
		else $error("closed event with state other than closed");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> $onehot(state_q))
		else $error("connection state lost its one-hot code");

endmodule

### dv/tb_tcp_client_connection_fsm.sv
module tb_tcp_client_connection_fsm;
	import tccf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned GAP_PCT = 18;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [SEQ_W-1:0] cfg_data = '0;

	tcp_client_connection_fsm u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Connection model: state code, send sequence, acknowledge number.
	logic [CODE_W-1:0] conn_code = CODE_CLOSED;
	logic [SEQ_W-1:0]  snd_seq = '0;
	logic [SEQ_W-1:0]  ack_num = '0;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int   n_queued = 0;
	int   n_seen = 0;
	int   n_err = 0;
	int   n_cycles = 0;
	bit   calm = 1'b0;

	function automatic rsp_t advance_connection(input req_t r);
		rsp_t o;
		o = '0;
		o.tx_kind = TX_NONE;
		o.event_res = EV_NONE;
		case (r.action)
			ACT_CONNECT: begin
				o.tx_kind = TX_SYN;
				o.tx_sequence = snd_seq;
				snd_seq = snd_seq + SEQ_W'(1);
				conn_code = CODE_SYN_SENT;
			end
			ACT_CLOSE: begin
				o.tx_kind = TX_FIN;
				o.tx_sequence = snd_seq;
				o.tx_acknowledge = ack_num;
				snd_seq = snd_seq + SEQ_W'(1);
				conn_code = CODE_FIN_WAIT1;
			end
			ACT_SEND: begin
				o.tx_kind = TX_DATA;
				o.tx_sequence = snd_seq;
				o.tx_acknowledge = ack_num;
				o.tx_length = r.send_length;
				snd_seq = snd_seq + SEQ_W'(r.send_length);
			end
			default: begin
				// a zero-length segment still consumes one sequence number
				ack_num = r.rx_sequence + ((r.rx_length != '0) ? SEQ_W'(r.rx_length) : SEQ_W'(1));
				case (conn_code)
					CODE_SYN_SENT: begin
						if (r.rx_syn && r.rx_ack) begin
							o.tx_kind = TX_ACK;
							o.event_res = EV_CONNECTED;
							conn_code = CODE_ESTABLISHED;
						end
					end
					CODE_ESTABLISHED: begin
						if (r.rx_length != '0) begin
							o.tx_kind = TX_ACK;
							o.event_res = EV_MESSAGE;
							o.message_length = r.rx_length;
						end else if (!r.rx_ack && r.rx_fin) begin
							o.tx_kind = TX_FINACK;
							conn_code = CODE_CLOSING;
						end
					end
					CODE_FIN_WAIT1: begin
						if (r.rx_ack) begin
							conn_code = CODE_FIN_WAIT2;
						end else if (r.rx_fin) begin
							o.tx_kind = TX_ACK;
							conn_code = CODE_CLOSING;
						end
					end
					CODE_FIN_WAIT2: begin
						if (r.rx_fin) begin
							o.tx_kind = TX_ACK;
							o.event_res = EV_CLOSED;
							conn_code = CODE_CLOSED;
						end
					end
					CODE_CLOSING: begin
						if (r.rx_ack) begin
							o.event_res = EV_CLOSED;
							conn_code = CODE_CLOSED;
						end
					end
					default: ;
				endcase
				if (o.tx_kind != TX_NONE) begin
					o.tx_sequence = snd_seq;
					o.tx_acknowledge = ack_num;
				end
			end
		endcase
		o.conn_state = conn_code;
		return o;
	endfunction

	// Driver: predict on acceptance, then present the next pending item.
	always @(posedge clk) begin
		if (req_valid && !req_stall)
			expected_rsps.push_back(advance_connection(req));
		if (!req_valid || !req_stall) begin
			if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= GAP_PCT)) begin
				req_valid <= 1'b1;
				req <= pending_reqs.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each response transaction with the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			n_seen++;
			if (expected_rsps.size() == 0) begin
				$error("unexpected response transaction");
				n_err++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.tx_kind !== want.tx_kind) begin
					$error("tx_kind: expected %0d, got %0d", want.tx_kind, rsp.tx_kind);
					n_err++;
				end
				if (rsp.tx_sequence !== want.tx_sequence) begin
					$error("tx_sequence: expected %h, got %h", want.tx_sequence, rsp.tx_sequence);
					n_err++;
				end
				if (rsp.tx_acknowledge !== want.tx_acknowledge) begin
					$error("tx_acknowledge: expected %h, got %h",
						want.tx_acknowledge, rsp.tx_acknowledge);
					n_err++;
				end
				if (rsp.tx_length !== want.tx_length) begin
					$error("tx_length: expected %0d, got %0d", want.tx_length, rsp.tx_length);
					n_err++;
				end
				if (rsp.event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res, rsp.event_res);
					n_err++;
				end
				if (rsp.message_length !== want.message_length) begin
					$error("message_length: expected %0d, got %0d",
						want.message_length, rsp.message_length);
					n_err++;
				end
				if (rsp.conn_state !== want.conn_state) begin
					$error("conn_state: expected %0d, got %0d", want.conn_state, rsp.conn_state);
					n_err++;
				end
			end
		end
		rsp_stall <= !calm && ($urandom_range(99) < GAP_PCT);
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic coin();
		return 1'($urandom_range(1));
	endfunction

	function automatic req_t mk_req(input action_t act, input logic [LEN_W-1:0] slen,
			input logic [SEQ_W-1:0] rseq, input logic [LEN_W-1:0] rlen,
			input logic syn, input logic ack, input logic fin);
		req_t r;
		r.action = act;
		r.send_length = slen;
		r.rx_sequence = rseq;
		r.rx_length = rlen;
		r.rx_syn = syn;
		r.rx_ack = ack;
		r.rx_fin = fin;
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return LEN_W'($urandom_range(15));
			default: return LEN_W'($urandom);
		endcase
	endfunction

	function automatic req_t noise_req();
		return mk_req(action_t'($urandom_range(3)), LEN_W'($urandom), $urandom,
			pick_len(), coin(), coin(), coin());
	endfunction

	// Request with random content in the fields the action ignores.
	function automatic req_t cmd_req(input action_t act, input logic [LEN_W-1:0] slen);
		return mk_req(act, slen, $urandom, LEN_W'($urandom), coin(), coin(), coin());
	endfunction

	function automatic req_t seg_req(input logic [LEN_W-1:0] rlen,
			input logic syn, input logic ack, input logic fin);
		return mk_req(ACT_RX, LEN_W'($urandom), $urandom, rlen, syn, ack, fin);
	endfunction

	task automatic enqueue(input req_t r);
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	task automatic await_idle();
		while (n_seen < n_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_initial_sequence(input logic [SEQ_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		snd_seq = v;
	endtask

	// One client session: open, exchange, then one of the close paths.
	task automatic queue_session();
		int n;
		enqueue(cmd_req(ACT_CONNECT, LEN_W'($urandom)));
		if ($urandom_range(5) == 0)
			enqueue(seg_req('0, 1'b1, 1'b0, coin()));
		enqueue(seg_req(($urandom_range(3) == 0) ? pick_len() : '0, 1'b1, 1'b1, coin()));
		n = $urandom_range(1, 8);
		repeat (n) begin
			case ($urandom_range(3))
				0: enqueue(cmd_req(ACT_SEND, pick_len()));
				1: enqueue(seg_req(pick_len(), coin(), coin(), coin()));
				2: enqueue(seg_req('0, coin(), 1'b1, coin()));
				default: begin
					if ($urandom_range(7) == 0)
						enqueue(noise_req());
					else
						enqueue(cmd_req(ACT_SEND, pick_len()));
				end
			endcase
		end
		case ($urandom_range(2))
			0: begin
				enqueue(cmd_req(ACT_CLOSE, LEN_W'($urandom)));
				enqueue(seg_req(pick_len(), coin(), 1'b1, coin()));
				if ($urandom_range(3) == 0)
					enqueue(seg_req('0, coin(), 1'b1, 1'b0));
				enqueue(seg_req(pick_len(), coin(), coin(), 1'b1));
			end
			1: begin
				enqueue(cmd_req(ACT_CLOSE, LEN_W'($urandom)));
				enqueue(seg_req(pick_len(), coin(), 1'b0, 1'b1));
				enqueue(seg_req(pick_len(), coin(), 1'b1, coin()));
			end
			default: begin
				enqueue(seg_req('0, coin(), 1'b0, 1'b1));
				if ($urandom_range(3) == 0)
					enqueue(seg_req(pick_len(), coin(), 1'b0, coin()));
				enqueue(seg_req(pick_len(), coin(), 1'b1, coin()));
			end
		endcase
	endtask

	initial begin
		logic [SEQ_W-1:0] seeds[5];
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: wrap of every counter, each state path and the ignored cases.
		load_initial_sequence(32'hFFFF_FFFF);
		enqueue(mk_req(ACT_RX, 16'h0000, 32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b1, 1'b1));
		enqueue(mk_req(ACT_CONNECT, 16'hFFFF, 32'h0000_0000, 16'hFFFF, 1'b0, 1'b0, 1'b0));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h1000_0000, 16'h0000, 1'b1, 1'b0, 1'b0));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h1234_5678, 16'h0000, 1'b1, 1'b1, 1'b0));
		enqueue(mk_req(ACT_SEND, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
		enqueue(mk_req(ACT_SEND, 16'hFFFF, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b0));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b1, 1'b1));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h8000_0000, 16'h0000, 1'b0, 1'b0, 1'b1));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h8000_0001, 16'h0000, 1'b1, 1'b0, 1'b1));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h8000_0002, 16'h0000, 1'b0, 1'b1, 1'b0));
		enqueue(mk_req(ACT_CONNECT, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b0));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'hFFFF_FFFE, 16'h0001, 1'b1, 1'b1, 1'b1));
		enqueue(mk_req(ACT_CLOSE, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b0));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h0000_0010, 16'h0000, 1'b0, 1'b0, 1'b1));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h0000_0011, 16'h0000, 1'b0, 1'b1, 1'b0));
		enqueue(mk_req(ACT_CLOSE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h0000_0020, 16'h0000, 1'b0, 1'b1, 1'b0));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h0000_0021, 16'h0005, 1'b1, 1'b1, 1'b0));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h0000_0030, 16'h0000, 1'b0, 1'b0, 1'b1));
		enqueue(mk_req(ACT_SEND, 16'h0001, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b0));
		enqueue(mk_req(ACT_CLOSE, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b0));
		enqueue(mk_req(ACT_CLOSE, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 1'b0, 1'b0));
		enqueue(mk_req(ACT_RX, 16'h0000, 32'h0000_0040, 16'h0000, 1'b0, 1'b1, 1'b1));
		await_idle();

		seeds[0] = 32'h0000_0000;
		seeds[1] = 32'hFFFF_FFF0;
		seeds[2] = $urandom;
		seeds[3] = 32'h7FFF_FFFF;
		seeds[4] = $urandom;
		for (int ph = 0; ph < 5; ph++) begin
			load_initial_sequence(seeds[ph]);
			// hold both sides busy for one whole phase
			calm = (ph == 2);
			target = n_queued + 240;
			while (n_queued < target) begin
				if ($urandom_range(99) < 15)
					enqueue(noise_req());
				else
					queue_session();
			end
			await_idle();
			calm = 1'b0;
		end

		repeat (10) @(posedge clk);
		if (expected_rsps.size() != 0) begin
			$error("%0d predicted responses never arrived", expected_rsps.size());
			n_err++;
		end
		if (n_err == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
sv/tccf_pkg.sv
sv/tcp_client_connection_fsm.sv
dv/tb_tcp_client_connection_fsm.sv
